@@ rtl/rtc_drift_compensator_assert.svh @@
// assertion macros used by the checker file of the drift compensator
`ifndef RTC_DRIFT_COMPENSATOR_ASSERT_SVH
`define RTC_DRIFT_COMPENSATOR_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define RDC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rdc check failed: same-cycle implication");

// next-cycle implication, disabled while reset is asserted
`define RDC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rdc check failed: next-cycle implication");

`endif

@@ rtl/rdc_pkg.sv @@
// shared widths, register codes and helper functions of the drift compensator
`default_nettype none

package rdc_pkg;

    localparam int RDC_SEC_W   = 7;
    localparam int RDC_MIN_W   = 7;
    localparam int RDC_HOUR_W  = 6;
    localparam int RDC_DAY_W   = 6;
    localparam int RDC_CORR_W  = 12;
    localparam int RDC_DRIFT_W = 14;
    localparam int RDC_TRIG_W  = 5;
    localparam int RDC_INTV_W  = 10;
    localparam int RDC_ADDR_W  = 4;
    localparam int RDC_DATA_W  = 32;

    typedef enum logic [1:0] {
        RDC_REG_DRIFT = 2'd0,
        RDC_REG_TRIG  = 2'd1,
        RDC_REG_INTV  = 2'd2
    } rdc_reg_t;

    // reciprocals for exact constant division: q = (x * m) >> shift
    localparam logic [20:0] RDC_RECIP3    = 21'd1398102;  // shift 22, x < 2^21
    localparam logic [20:0] RDC_RECIP100  = 21'd1342178;  // shift 27, x < 2^20
    localparam logic [18:0] RDC_RECIP3600 = 19'd298262;   // shift 30, x < 2^18
    localparam logic [18:0] RDC_RECIP60   = 19'd279621;   // shift 24, x < 2^18

    localparam logic [17:0] RDC_SEC_PER_DAY = 18'd86400;

    function automatic logic [6:0] rdc_from_bcd7(input logic [6:0] v);
        return 7'(v[6:4]) * 7'd10 + 7'(v[3:0]);
    endfunction

    function automatic logic [5:0] rdc_from_bcd6(input logic [5:0] v);
        return 6'(v[5:4]) * 6'd10 + 6'(v[3:0]);
    endfunction

    // binary below 64 to two bcd digits, tens digit kept to three bits
    function automatic logic [6:0] rdc_to_bcd7(input logic [5:0] v);
        logic [13:0] p;
        logic [2:0]  t;
        logic [5:0]  o;
        p = 14'(v) * 14'd205;
        t = p[13:11];
        o = 6'(v - 6'(t) * 6'd10);
        return {t, o[3:0]};
    endfunction

endpackage

`default_nettype wire

@@ rtl/rdc_if.sv @@
// valid/ready channels for clock polls and correction results
`default_nettype none

interface rdc_poll_if;
    import rdc_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [RDC_SEC_W-1:0]  second_bcd;
    logic [RDC_MIN_W-1:0]  minute_bcd;
    logic [RDC_HOUR_W-1:0] hour_bcd;
    logic [RDC_DAY_W-1:0]  day_bcd;

    modport source (output valid, second_bcd, minute_bcd, hour_bcd, day_bcd, input ready);
    modport sink   (input valid, second_bcd, minute_bcd, hour_bcd, day_bcd, output ready);
endinterface

interface rdc_result_if;
    import rdc_pkg::*;

    logic                  valid;
    logic                  ready;
    logic                  write_back;
    logic [RDC_SEC_W-1:0]  new_second_bcd;
    logic [RDC_MIN_W-1:0]  new_minute_bcd;
    logic [RDC_HOUR_W-1:0] new_hour_bcd;
    logic [RDC_CORR_W-1:0] correction_seconds;
    logic                  record_updated;

    modport source (output valid, write_back, new_second_bcd, new_minute_bcd, new_hour_bcd,
                    correction_seconds, record_updated, input ready);
    modport sink   (input valid, write_back, new_second_bcd, new_minute_bcd, new_hour_bcd,
                    correction_seconds, record_updated, output ready);
endinterface

`default_nettype wire

@@ rtl/rtc_drift_compensator.sv @@
// drift compensator top level: apb registers and the correction pipeline
//
//  channel   dir  handshake       payload
//  poll      in   valid/ready     second_bcd minute_bcd hour_bcd day_bcd
//  result    out  valid/ready     write_back new_*_bcd correction_seconds record_updated
//  apb       in   psel/penable    paddr pwdata -> prdata, pready tied high
//
// one request per clock while the result channel does not stall; each result is held
// in stages 0 to 7 of the nine-stage pipeline before it reaches the output register, stage 8
// every stage has its own valid bit, so a stalled result only backs up the stages
// behind it and bubbles are squeezed out
// reset zeroes drift, trigger, valids and carry; sets interval 24, record day 1 hour 0
`default_nettype none

module rtc_drift_compensator (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [rdc_pkg::RDC_ADDR_W-1:0] paddr,
    input  wire logic [rdc_pkg::RDC_DATA_W-1:0] pwdata,
    output logic      [rdc_pkg::RDC_DATA_W-1:0] prdata,
    output logic                               pready,
    rdc_poll_if.sink                           poll,
    rdc_result_if.source                       result
);
    import rdc_pkg::*;

    typedef struct packed {
        logic [RDC_SEC_W-1:0]  sec;
        logic [RDC_MIN_W-1:0]  min;
        logic [RDC_HOUR_W-1:0] hour;
        logic [RDC_DAY_W-1:0]  day;
    } st0_t;

    typedef struct packed {
        logic        due;
        logic [23:0] prod;
        logic [17:0] tod;
    } st1_t;

    typedef struct packed {
        logic        due;
        logic [19:0] q24;
        logic [17:0] tod;
    } st2_t;

    typedef struct packed {
        logic        due;
        logic [19:0] q24;
        logic [12:0] quo;
        logic [17:0] tod;
    } st3_t;

    typedef struct packed {
        logic        due;
        logic [12:0] corr;
        logic [17:0] tod;
    } st4_t;

    typedef struct packed {
        logic        due;
        logic [12:0] corr;
        logic [17:0] todc;
    } st5_t;

    typedef struct packed {
        logic        due;
        logic [12:0] corr;
        logic [17:0] todc;
        logic [5:0]  hr;
        logic [11:0] mt;
    } st6_t;

    typedef struct packed {
        logic                  due;
        logic                  wb;
        logic [RDC_CORR_W-1:0] csat;
        logic [5:0]            sec;
        logic [5:0]            min;
        logic [4:0]            hr;
    } st7_t;

    typedef struct packed {
        logic                  write_back;
        logic [RDC_SEC_W-1:0]  new_sec;
        logic [RDC_MIN_W-1:0]  new_min;
        logic [RDC_HOUR_W-1:0] new_hour;
        logic [RDC_CORR_W-1:0] corr;
        logic                  rec;
    } st8_t;

    // configuration and correction record
    logic [RDC_DRIFT_W-1:0] drift_reg;
    logic [RDC_TRIG_W-1:0]  trig_reg;
    logic [RDC_INTV_W-1:0]  intv_reg;
    logic [4:0]             last_day_reg;
    logic [4:0]             last_hour_reg;
    logic [6:0]             carried_reg;
    logic [6:0]             carried_next;

    logic [8:0] vld_reg;
    logic [8:0] vld_next;
    logic [8:0] rdy;

    st0_t s0_reg, s0_next;
    st1_t s1_reg, s1_next;
    st2_t s2_reg, s2_next;
    st3_t s3_reg, s3_next;
    st4_t s4_reg, s4_next;
    st5_t s5_reg, s5_next;
    st6_t s6_reg, s6_next;
    st7_t s7_reg, s7_next;
    st8_t s8_reg, s8_next;

    logic wr_en;
    logic mv01;
    logic mv34;

    // stage 1 signals
    logic [6:0]  sec_dec;
    logic [6:0]  min_dec;
    logic [5:0]  hour_dec;
    logic [5:0]  day_dec;
    logic [4:0]  day_sat;
    logic [4:0]  diff;
    logic [9:0]  elapsed;
    logic        same_day;
    logic        skip;

    // wide products
    logic [41:0] q24_full;
    logic [40:0] quo_full;
    logic [36:0] hr_full;
    logic [36:0] mt_full;

    // stage 4 signals
    logic [19:0] quo_x100;
    logic [6:0]  rem_cs;
    logic [7:0]  sum_cs;
    logic        cs_wrap;

    // stage 7 signals
    logic [17:0] mt_x60;
    logic [11:0] hr_x60;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drift_reg <= '0;
            trig_reg  <= '0;
            intv_reg  <= 10'd24;
        end
        else if (wr_en)
        begin
            case (paddr[3:2])
                RDC_REG_DRIFT: drift_reg <= pwdata[RDC_DRIFT_W-1:0];
                RDC_REG_TRIG:  trig_reg  <= pwdata[RDC_TRIG_W-1:0];
                RDC_REG_INTV:  intv_reg  <= pwdata[RDC_INTV_W-1:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            RDC_REG_DRIFT: prdata = RDC_DATA_W'(drift_reg);
            RDC_REG_TRIG:  prdata = RDC_DATA_W'(trig_reg);
            RDC_REG_INTV:  prdata = RDC_DATA_W'(intv_reg);
            default:       prdata = '0;
        endcase
    end

    // ready ripples back from the output; an empty stage always takes data
    assign rdy[8] = !vld_reg[8] || result.ready;
    for (genvar g = 0; g < 8; g++)
    begin : g_rdy
        assign rdy[g] = !vld_reg[g] || rdy[g+1];
    end

    assign poll.ready = rdy[0];
    assign vld_next   = {vld_reg[7:0], poll.valid};
    assign mv01       = vld_reg[0] && rdy[1];
    assign mv34       = vld_reg[3] && rdy[4];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= (rdy & vld_next) | (~rdy & vld_reg);
        end
    end

    // correction record: day and hour are taken when the poll leaves stage 0,
    // the remainder when it leaves stage 3
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_day_reg  <= 5'd1;
            last_hour_reg <= '0;
            carried_reg   <= '0;
        end
        else
        begin
            if (mv01 && s1_next.due)
            begin
                last_day_reg  <= day_sat;
                last_hour_reg <= hour_dec[4:0];
            end
            if (mv34 && s3_reg.due)
            begin
                carried_reg <= carried_next;
            end
        end
    end

    // stage 0: input register
    always_comb
    begin
        s0_next.sec  = poll.second_bcd;
        s0_next.min  = poll.minute_bcd;
        s0_next.hour = poll.hour_bcd;
        s0_next.day  = poll.day_bcd;
    end

    // stage 1: decode, decide whether a correction is due, drift times hours
    always_comb
    begin
        sec_dec  = rdc_from_bcd7(s0_reg.sec);
        min_dec  = rdc_from_bcd7(s0_reg.min);
        hour_dec = rdc_from_bcd6(s0_reg.hour);
        day_dec  = rdc_from_bcd6(s0_reg.day);
        day_sat  = (day_dec > 6'd31) ? 5'd31 : day_dec[4:0];
        same_day = (day_sat == last_day_reg);
        skip     = same_day && (hour_dec == {1'b0, last_hour_reg});
        // day wrap assumes a 31-day month
        if (day_sat > last_day_reg)
            diff = 5'(day_sat - last_day_reg);
        else
            diff = 5'(6'(day_sat) + 6'd31 - 6'(last_day_reg));
        elapsed = same_day ? intv_reg : 10'(diff) * 10'd24;

        s1_next.due  = (drift_reg != '0) && (hour_dec == {1'b0, trig_reg}) && !skip
                       && (elapsed >= intv_reg);
        s1_next.prod = 24'(drift_reg) * 24'(elapsed);
        s1_next.tod  = 18'(sec_dec) + 18'(min_dec) * 18'd60 + 18'(hour_dec) * 18'd3600;
    end

    // stage 2: divide by 24 as a shift and a reciprocal of 3
    always_comb
    begin
        q24_full    = 42'(s1_reg.prod[23:3]) * 42'(RDC_RECIP3);
        s2_next.due = s1_reg.due;
        s2_next.q24 = q24_full[41:22];
        s2_next.tod = s1_reg.tod;
    end

    // stage 3: whole seconds of the new gain
    always_comb
    begin
        quo_full    = 41'(s2_reg.q24) * 41'(RDC_RECIP100);
        s3_next.due = s2_reg.due;
        s3_next.q24 = s2_reg.q24;
        s3_next.quo = quo_full[39:27];
        s3_next.tod = s2_reg.tod;
    end

    // stage 4: fold in the carried hundredths
    always_comb
    begin
        quo_x100     = 20'(s3_reg.quo) * 20'd100;
        rem_cs       = 7'(s3_reg.q24 - quo_x100);
        sum_cs       = 8'(rem_cs) + 8'(carried_reg);
        cs_wrap      = (sum_cs >= 8'd100);
        carried_next = cs_wrap ? 7'(sum_cs - 8'd100) : sum_cs[6:0];
        s4_next.due  = s3_reg.due;
        s4_next.corr = s3_reg.quo + 13'(cs_wrap);
        s4_next.tod  = s3_reg.tod;
    end

    // stage 5: subtract, wrapping at midnight
    always_comb
    begin
        s5_next.due  = s4_reg.due;
        s5_next.corr = s4_reg.corr;
        if (s4_reg.tod < 18'(s4_reg.corr))
            s5_next.todc = 18'(s4_reg.tod + RDC_SEC_PER_DAY - 18'(s4_reg.corr));
        else
            s5_next.todc = 18'(s4_reg.tod - 18'(s4_reg.corr));
    end

    // stage 6: hours and total minutes of the corrected time
    always_comb
    begin
        hr_full      = 37'(s5_reg.todc) * 37'(RDC_RECIP3600);
        mt_full      = 37'(s5_reg.todc) * 37'(RDC_RECIP60);
        s6_next.due  = s5_reg.due;
        s6_next.corr = s5_reg.corr;
        s6_next.todc = s5_reg.todc;
        s6_next.hr   = hr_full[35:30];
        s6_next.mt   = mt_full[35:24];
    end

    // stage 7: split into fields; only the low bits of each difference matter
    always_comb
    begin
        mt_x60       = 18'(s6_reg.mt) * 18'd60;
        hr_x60       = 12'(s6_reg.hr) * 12'd60;
        s7_next.due  = s6_reg.due;
        s7_next.wb   = s6_reg.due && (s6_reg.corr != '0);
        if (!s6_reg.due)
            s7_next.csat = '0;
        else if (s6_reg.corr > 13'd4095)
            s7_next.csat = '1;
        else
            s7_next.csat = s6_reg.corr[11:0];
        s7_next.sec = 6'(s6_reg.todc - mt_x60);
        s7_next.min = 6'(s6_reg.mt - hr_x60);
        s7_next.hr  = (s6_reg.hr >= 6'd24) ? 5'(s6_reg.hr - 6'd24) : s6_reg.hr[4:0];
    end

    // stage 8: bcd encoding into the output register
    always_comb
    begin
        s8_next.write_back = s7_reg.wb;
        s8_next.new_sec    = s7_reg.wb ? rdc_to_bcd7(s7_reg.sec) : '0;
        s8_next.new_min    = s7_reg.wb ? rdc_to_bcd7(s7_reg.min) : '0;
        s8_next.new_hour   = s7_reg.wb ? 6'(rdc_to_bcd7(6'(s7_reg.hr))) : '0;
        s8_next.corr       = s7_reg.csat;
        s8_next.rec        = s7_reg.due;
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0]) s0_reg <= s0_next;
        if (rdy[1]) s1_reg <= s1_next;
        if (rdy[2]) s2_reg <= s2_next;
        if (rdy[3]) s3_reg <= s3_next;
        if (rdy[4]) s4_reg <= s4_next;
        if (rdy[5]) s5_reg <= s5_next;
        if (rdy[6]) s6_reg <= s6_next;
        if (rdy[7]) s7_reg <= s7_next;
        if (rdy[8]) s8_reg <= s8_next;
    end

    assign result.valid              = vld_reg[8];
    assign result.write_back         = s8_reg.write_back;
    assign result.new_second_bcd     = s8_reg.new_sec;
    assign result.new_minute_bcd     = s8_reg.new_min;
    assign result.new_hour_bcd       = s8_reg.new_hour;
    assign result.correction_seconds = s8_reg.corr;
    assign result.record_updated     = s8_reg.rec;

endmodule

`default_nettype wire

@@ rtl/rdc_checker.sv @@
// port-level checks on the drift compensator results, bound to the top level
`default_nettype none
`include "rtc_drift_compensator_assert.svh"

module rdc_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          result_valid,
    input wire logic                          result_ready,
    input wire logic                          result_write_back,
    input wire logic [rdc_pkg::RDC_SEC_W-1:0]  result_new_second_bcd,
    input wire logic [rdc_pkg::RDC_MIN_W-1:0]  result_new_minute_bcd,
    input wire logic [rdc_pkg::RDC_HOUR_W-1:0] result_new_hour_bcd,
    input wire logic [rdc_pkg::RDC_CORR_W-1:0] result_correction_seconds,
    input wire logic                          result_record_updated
);
    import rdc_pkg::*;

    // a stalled result keeps its write-back flag, correction and seconds field
    `RDC_ASSERT_NXT(a_result_hold, clk, rst_n, result_valid && !result_ready, result_valid && $stable(result_write_back) && $stable(result_correction_seconds) && $stable(result_new_second_bcd))

    // no write-back means the corrected time fields are cleared
    `RDC_ASSERT_IMP(a_time_cleared, clk, rst_n, result_valid && !result_write_back, result_new_second_bcd == '0 && result_new_minute_bcd == '0 && result_new_hour_bcd == '0)

    // nothing is corrected unless the record was stored
    `RDC_ASSERT_IMP(a_no_record_no_corr, clk, rst_n, result_valid && !result_record_updated, !result_write_back && result_correction_seconds == '0)

    // a write-back always carries a nonzero correction
    `RDC_ASSERT_IMP(a_wb_has_corr, clk, rst_n, result_valid && result_write_back, result_record_updated && result_correction_seconds != '0)

endmodule

bind rtc_drift_compensator rdc_checker u_rdc_checker (
    .clk                       (clk),
    .rst_n                     (rst_n),
    .result_valid              (result.valid),
    .result_ready              (result.ready),
    .result_write_back         (result.write_back),
    .result_new_second_bcd     (result.new_second_bcd),
    .result_new_minute_bcd     (result.new_minute_bcd),
    .result_new_hour_bcd       (result.new_hour_bcd),
    .result_correction_seconds (result.correction_seconds),
    .result_record_updated     (result.record_updated)
);

`default_nettype wire

@@ tb/sv/tb_rtc_drift_compensator.sv @@
// testbench for the rtc drift compensator: directed and random polls against a local model
`timescale 1ns / 100ps

module tb_rtc_drift_compensator;
    import rdc_pkg::*;

    localparam int PIPE_LATENCY = 8;

    typedef struct packed {
        logic [RDC_SEC_W-1:0]  second_bcd;
        logic [RDC_MIN_W-1:0]  minute_bcd;
        logic [RDC_HOUR_W-1:0] hour_bcd;
        logic [RDC_DAY_W-1:0]  day_bcd;
    } poll_t;

    typedef struct packed {
        logic                  write_back;
        logic [RDC_SEC_W-1:0]  new_second_bcd;
        logic [RDC_MIN_W-1:0]  new_minute_bcd;
        logic [RDC_HOUR_W-1:0] new_hour_bcd;
        logic [RDC_CORR_W-1:0] correction_seconds;
        logic                  record_updated;
    } correction_t;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_RANDOM,
        RX_PATTERN,
        RX_CHOKED
    } rx_mode_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [RDC_ADDR_W-1:0] paddr;
    logic [RDC_DATA_W-1:0] pwdata;
    logic [RDC_DATA_W-1:0] prdata;
    logic                  pready;

    rdc_poll_if   poll_bus ();
    rdc_result_if result_bus ();

    rtc_drift_compensator uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .poll    (poll_bus),
        .result  (result_bus)
    );

    // local copy of the registers and the correction record
    int unsigned cfg_drift;
    int unsigned cfg_trigger;
    int unsigned cfg_interval;
    int unsigned rec_day;
    int unsigned rec_hour;
    int unsigned carry_cs;

    correction_t correction_q[$];
    int          failures = 0;
    int          burst_left = 0;
    int unsigned cal_day = 1;
    poll_t       last_poll = '0;

    rx_mode_t    rx_mode = RX_OPEN;
    int unsigned rx_mode_left = 0;
    int unsigned rx_cycle = 0;
    logic [7:0]  rx_mask = 8'hFF;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int unsigned bcd_decode(input logic [6:0] v);
        return int'(v[6:4]) * 10 + int'(v[3:0]);
    endfunction

    function automatic logic [6:0] bcd_encode(input int unsigned v);
        logic [3:0] tens;
        logic [3:0] ones;
        tens = 4'((v / 10) % 10);
        ones = 4'(v % 10);
        return 7'({tens, ones});
    endfunction

    function automatic correction_t predict_correction(input poll_t p);
        correction_t r;
        int unsigned sec_v;
        int unsigned min_v;
        int unsigned hour_v;
        int unsigned day_v;
        int unsigned hours_gone;
        int unsigned total_cs;
        int unsigned corr_s;
        int unsigned tod;
        int          diff;
        r = '0;
        sec_v  = bcd_decode(p.second_bcd);
        min_v  = bcd_decode(p.minute_bcd);
        hour_v = bcd_decode({1'b0, p.hour_bcd});
        day_v  = bcd_decode({1'b0, p.day_bcd});
        if (day_v > 31)
            day_v = 31;
        if (cfg_drift == 0 || hour_v != cfg_trigger)
            return r;
        // same day and hour as the stored record: nothing to do
        if (day_v == rec_day && hour_v == rec_hour)
            return r;
        if (day_v == rec_day)
            hours_gone = cfg_interval;
        else
        begin
            diff = int'(day_v) - int'(rec_day);
            if (diff <= 0)
                diff += 31;
            hours_gone = diff * 24;
        end
        if (hours_gone < cfg_interval)
            return r;
        total_cs = cfg_drift * hours_gone / 24 + carry_cs;
        corr_s = total_cs / 100;
        if (corr_s > 0)
        begin
            tod = sec_v + min_v * 60 + hour_v * 3600;
            // wraps past midnight, date stays as it is
            tod = (tod < corr_s) ? tod + 86400 - corr_s : tod - corr_s;
            r.write_back     = 1'b1;
            r.new_second_bcd = bcd_encode(tod % 60);
            r.new_minute_bcd = bcd_encode((tod / 60) % 60);
            r.new_hour_bcd   = RDC_HOUR_W'(bcd_encode((tod / 3600) % 24));
        end
        r.correction_seconds = (corr_s > 4095) ? '1 : RDC_CORR_W'(corr_s);
        r.record_updated = 1'b1;
        rec_day  = day_v;
        rec_hour = hour_v & 31;
        carry_cs = total_cs % 100;
        return r;
    endfunction

    task automatic write_register(input rdc_reg_t sel, input int unsigned value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= RDC_ADDR_W'({sel, 2'b00});
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        case (sel)
            RDC_REG_DRIFT: cfg_drift = value & 32'h3FFF;
            RDC_REG_TRIG:  cfg_trigger = value & 32'h1F;
            RDC_REG_INTV:  cfg_interval = value & 32'h3FF;
            default: ;
        endcase
    endtask

    // waits for the pipeline to drain, then writes all three registers
    task automatic configure(input int unsigned drift, input int unsigned trig,
                             input int unsigned intv);
        poll_bus.valid <= 1'b0;
        while (correction_q.size() != 0)
            @(posedge clk);
        write_register(RDC_REG_DRIFT, drift);
        write_register(RDC_REG_TRIG, trig);
        write_register(RDC_REG_INTV, intv);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_poll(input logic [6:0] s, input logic [6:0] m,
                             input logic [5:0] h, input logic [5:0] d);
        poll_t p;
        p = {s, m, h, d};
        poll_bus.valid      <= 1'b1;
        poll_bus.second_bcd <= s;
        poll_bus.minute_bcd <= m;
        poll_bus.hour_bcd   <= h;
        poll_bus.day_bcd    <= d;
        @(posedge clk);
        while (!poll_bus.ready)
            @(posedge clk);
        correction_q.push_back(predict_correction(p));
        last_poll = p;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 200)
                                                     : $urandom_range(1, 24);
            poll_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 12))
                @(posedge clk);
        end
        else
            burst_left--;
    endtask

    task automatic compare_field(input string name, input logic [15:0] want,
                                 input logic [15:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            failures++;
        end
    endtask

    task automatic check_correction();
        correction_t want;
        if (correction_q.size() == 0)
        begin
            $error("result with no request outstanding");
            failures++;
        end
        else
        begin
            want = correction_q.pop_front();
            compare_field("write_back", want.write_back, result_bus.write_back);
            compare_field("new_second_bcd", want.new_second_bcd, result_bus.new_second_bcd);
            compare_field("new_minute_bcd", want.new_minute_bcd, result_bus.new_minute_bcd);
            compare_field("new_hour_bcd", want.new_hour_bcd, result_bus.new_hour_bcd);
            compare_field("correction_seconds", want.correction_seconds,
                          result_bus.correction_seconds);
            compare_field("record_updated", want.record_updated, result_bus.record_updated);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && result_bus.valid && result_bus.ready)
            check_correction();
        if (rx_mode_left == 0)
        begin
            rx_mode      = rx_mode_t'($urandom_range(0, 3));
            rx_mode_left = $urandom_range(16, 400);
            rx_mask      = 8'($urandom);
        end
        else
            rx_mode_left--;
        rx_cycle++;
        case (rx_mode)
            RX_OPEN:    result_bus.ready <= 1'b1;
            RX_RANDOM:  result_bus.ready <= ($urandom_range(0, 3) != 0);
            RX_PATTERN: result_bus.ready <= rx_mask[rx_cycle % 8];
            default:    result_bus.ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    task automatic test_disabled_polls();
        configure(0, 0, 24);
        send_poll(7'h7F, 7'h7F, 6'h3F, 6'h3F);
        send_poll(7'h00, 7'h00, 6'h00, 6'h00);
        send_poll(7'h59, 7'h59, 6'h00, 6'h02);
    endtask

    task automatic test_directed_cases();
        configure(1200, 0, 24);
        send_poll(7'h10, 7'h20, 6'h05, 6'h02);
        send_poll(7'h00, 7'h00, 6'h00, 6'h01);
        // a few seconds past midnight, correction reaches back into the day before
        send_poll(7'h05, 7'h00, 6'h00, 6'h02);
        send_poll(7'h30, 7'h10, 6'h00, 6'h02);
        // day number goes down: month rollover
        send_poll(7'h00, 7'h30, 6'h00, 6'h01);

        configure(50, 23, 24);
        send_poll(7'h00, 7'h00, 6'h23, 6'h03);
        send_poll(7'h00, 7'h00, 6'h23, 6'h04);
        send_poll(7'h00, 7'h00, 6'h23, 6'h05);
        // low nibbles above nine
        send_poll(7'h5F, 7'h4C, 6'h23, 6'h0F);
        send_poll(7'h00, 7'h00, 6'h23, 6'h3F);
        send_poll(7'h00, 7'h00, 6'h23, 6'h00);

        // interval of zero: every fresh trigger-hour poll is due
        configure(9999, 12, 0);
        send_poll(7'h00, 7'h00, 6'h12, 6'h31);
        send_poll(7'h00, 7'h00, 6'h12, 6'h31);
        send_poll(7'h45, 7'h00, 6'h12, 6'h01);

        // same-day match with a long interval saturates the correction seconds field
        configure(9999, 13, 1000);
        send_poll(7'h00, 7'h05, 6'h13, 6'h01);

        configure(9999, 0, 744);
        send_poll(7'h00, 7'h00, 6'h00, 6'h02);
        send_poll(7'h00, 7'h00, 6'h00, 6'h01);
        send_poll(7'h59, 7'h59, 6'h1F, 6'h1F);
    endtask

    task automatic run_calendar_polls(input int unsigned drift, input int unsigned trig,
                                      input int unsigned intv, input int unsigned count);
        int unsigned pick;
        int unsigned h;
        configure(drift, trig, intv);
        for (int unsigned i = 0; i < count; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 12)
                send_poll(7'($urandom), 7'($urandom), 6'($urandom), 6'($urandom));
            else if (pick < 22)
                send_poll(last_poll.second_bcd, last_poll.minute_bcd,
                          last_poll.hour_bcd, last_poll.day_bcd);
            else
            begin
                // walk the calendar forward, mostly landing on the trigger hour
                if ($urandom_range(0, 9) == 0)
                    cal_day += $urandom_range(4, 40);
                else
                    cal_day += $urandom_range(0, 2);
                while (cal_day > 31)
                    cal_day -= 31;
                h = ($urandom_range(0, 9) < 7) ? cfg_trigger : $urandom_range(0, 23);
                send_poll(bcd_encode($urandom_range(0, 59)), bcd_encode($urandom_range(0, 59)),
                          6'(bcd_encode(h)), 6'(bcd_encode(cal_day)));
            end
        end
    endtask

    task automatic test_random_phases();
        run_calendar_polls(1, 0, 1, 200);
        run_calendar_polls(9999, 23, 744, 200);
        run_calendar_polls(250, 7, 24, 200);
        run_calendar_polls(0, 12, 24, 100);
        run_calendar_polls(4321, 0, 0, 200);
        run_calendar_polls(9999, 12, 48, 200);
        run_calendar_polls(777, 18, 168, 200);
        run_calendar_polls($urandom_range(1, 9999), $urandom_range(0, 23),
                           $urandom_range(1, 744), 200);
    endtask

    initial
    begin
        rst_n                 <= 1'b0;
        psel                  <= 1'b0;
        penable               <= 1'b0;
        pwrite                <= 1'b0;
        paddr                 <= '0;
        pwdata                <= '0;
        poll_bus.valid        <= 1'b0;
        poll_bus.second_bcd   <= '0;
        poll_bus.minute_bcd   <= '0;
        poll_bus.hour_bcd     <= '0;
        poll_bus.day_bcd      <= '0;
        cfg_drift    = 0;
        cfg_trigger  = 0;
        cfg_interval = 24;
        rec_day      = 1;
        rec_hour     = 0;
        carry_cs     = 0;
        repeat (9)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_disabled_polls();
        test_directed_cases();
        test_random_phases();

        poll_bus.valid <= 1'b0;
        while (correction_q.size() != 0)
            @(posedge clk);
        repeat (2 * PIPE_LATENCY)
            @(posedge clk);
        if (failures == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

@@ rtc_drift_compensator.f @@
+incdir+rtl
rtl/rdc_pkg.sv
rtl/rdc_if.sv
rtl/rtc_drift_compensator.sv
rtl/rdc_checker.sv
tb/sv/tb_rtc_drift_compensator.sv
